[rtl/mvcp_pkg.sv]
// Shared constants and types for the mixer voice channel picker.
`default_nettype none
package mvcp_pkg;

    localparam int CHANNEL_COUNT = 32;
    localparam int IDX_W         = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int CNT_W         = IDX_W + 1;

    localparam logic [31:0] LIFE_CEILING = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic [9:0]  owner_entity;
        logic [7:0]  owner_subchannel;
        logic [31:0] end_time;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             rel_en;
        logic [IDX_W-1:0] rel_idx;
        logic             clr;
    } table_cmd_t;

    typedef struct packed {
        logic             start;
        logic             eval;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } pick_t;

endpackage
`default_nettype wire

[rtl/mvcp_table.sv]
// Channel table: entry memory with per-entry valid and active flags.
`default_nettype none
module mvcp_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mvcp_pkg::table_cmd_t      cmd,
    input  wire mvcp_pkg::entry_t          wr_data,
    input  wire logic [mvcp_pkg::IDX_W-1:0] rd_addr,
    output mvcp_pkg::entry_t               rd_entry,
    output logic                           rd_active
);
    import mvcp_pkg::*;

    entry_t                   mem [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] valid_reg;
    logic [CHANNEL_COUNT-1:0] active_reg;
    entry_t                   rd_data_reg;
    logic                     rd_valid_reg;
    logic                     rd_active_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            active_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            rd_active_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= valid_reg[rd_addr];
            rd_active_reg <= active_reg[rd_addr];
            priority if (cmd.clr)
            begin
                valid_reg  <= '0;
                active_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                valid_reg[cmd.wr_idx]  <= 1'b1;
                active_reg[cmd.wr_idx] <= 1'b1;
            end
            else if (cmd.rel_en)
            begin
                active_reg[cmd.rel_idx] <= 1'b0;
            end
        end
    end

    // never-written or cleared entries read as all zero
    assign rd_entry  = rd_valid_reg ? rd_data_reg : '0;
    assign rd_active = rd_active_reg;

endmodule
`default_nettype wire

[rtl/mvcp_scan.sv]
// Scan datapath: tracks the first owner match and the least remaining life.
`default_nettype none
module mvcp_scan (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mvcp_pkg::scan_ctl_t ctl,
    input  wire mvcp_pkg::entry_t   entry,
    input  wire logic               active,
    input  wire logic [9:0]         req_entity,
    input  wire logic [7:0]         req_sub,
    input  wire logic [30:0]        req_now,
    input  wire logic [9:0]         player,
    output mvcp_pkg::pick_t         pick
);
    import mvcp_pkg::*;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             best_found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_reg;

    logic        is_match;
    logic        is_protected;
    logic [31:0] life;
    logic        is_better;

    always_comb
    begin
        is_match     = (req_sub != 8'd0) && (entry.owner_entity == req_entity) &&
                       (entry.owner_subchannel == req_sub);
        is_protected = (entry.owner_entity == player) && (req_entity != player) && active;
        life         = entry.end_time - {1'b0, req_now};
        is_better    = $signed(life) < $signed(best_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (ctl.start)
        begin
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (ctl.eval && !match_found_reg)
        begin
            if (is_match)
            begin
                match_found_reg <= 1'b1;
            end
            else if (!is_protected && is_better)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            best_reg <= LIFE_CEILING;
        end
        else if (ctl.eval && !match_found_reg)
        begin
            if (is_match)
            begin
                match_idx_reg <= ctl.idx;
            end
            else if (!is_protected && is_better)
            begin
                best_reg     <= life;
                best_idx_reg <= ctl.idx;
            end
        end
    end

    // an owner match beats any stolen channel
    assign pick.hit = match_found_reg || best_found_reg;
    assign pick.idx = match_found_reg ? match_idx_reg : best_idx_reg;

endmodule
`default_nettype wire

[rtl/mixer_voice_channel_picker.sv]
// Top level of the mixer voice channel picker: sequencer, config and result register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in       | in        | in_valid / in_stall  | op, entity_number, entity_channel,
//           |           |                      | now_time, sound_length, release_index
//  out      | out       | out_valid / out_stall| found, picked_index
//  cfg      | in        | cfg_wr_en            | cfg_wr_data (player entity)
//
//  A start item is accepted, then reads each table entry from the channel memory in turn,
//  evaluating each entry once its registered read returns, and finally writes back and
//  registers the result; a stalled output holds the finish step. Release, clear and unused
//  ops go from accept straight to the finish step. One item is in work at a time.
//  Reset clears the table at once through per-entry valid flags; no clearing pass.
//  A stalled result holds in the output register while the next item is accepted.
`default_nettype none
module mixer_voice_channel_picker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [9:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [9:0]  entity_number,
    input  wire logic [7:0]  entity_channel,
    input  wire logic [30:0] now_time,
    input  wire logic [23:0] sound_length,
    input  wire logic [4:0]  release_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [4:0]       picked_index
);
    import mvcp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [9:0]       player_reg;
    op_t              op_reg;
    logic [9:0]       ent_reg;
    logic [7:0]       sub_reg;
    logic [30:0]      now_reg;
    logic [23:0]      len_reg;
    logic [4:0]       rel_reg;
    logic             out_valid_reg;
    logic             found_reg;
    logic [4:0]       picked_reg;

    logic             accept;
    logic             fin_go;
    logic             rel_ok;
    table_cmd_t       tcmd;
    entry_t           wr_data;
    entry_t           rd_entry;
    logic             rd_active;
    logic [IDX_W-1:0] rd_addr;
    scan_ctl_t        sctl;
    pick_t            pick;
    logic [CNT_W-1:0] eval_cnt;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign fin_go   = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign rel_ok   = (32'(rel_reg) < 32'(CHANNEL_COUNT));
    assign eval_cnt = cnt_reg - CNT_W'(1);

    always_comb
    begin
        rd_addr    = cnt_reg[IDX_W-1:0];
        sctl.start = accept && (op_t'(op) == OP_START);
        sctl.eval  = (state_reg == ST_SCAN) && (cnt_reg != '0);
        sctl.idx   = eval_cnt[IDX_W-1:0];

        tcmd.wr_en   = fin_go && (op_reg == OP_START) && pick.hit;
        tcmd.wr_idx  = pick.idx;
        tcmd.rel_en  = fin_go && (op_reg == OP_RELEASE) && rel_ok;
        tcmd.rel_idx = IDX_W'(rel_reg);
        tcmd.clr     = fin_go && (op_reg == OP_CLEAR);

        wr_data.owner_entity     = ent_reg;
        wr_data.owner_subchannel = sub_reg;
        wr_data.end_time         = {1'b0, now_reg} + {8'd0, len_reg};
    end

    mvcp_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (tcmd),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .rd_active (rd_active)
    );

    mvcp_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sctl),
        .entry      (rd_entry),
        .active     (rd_active),
        .req_entity (ent_reg),
        .req_sub    (sub_reg),
        .req_now    (now_reg),
        .player     (player_reg),
        .pick       (pick)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_reg <= 10'd1;
        end
        else if (cfg_wr_en)
        begin
            player_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(op);
            ent_reg <= entity_number;
            sub_reg <= entity_channel;
            now_reg <= now_time;
            len_reg <= sound_length;
            rel_reg <= release_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            picked_reg    <= '0;
        end
        else
        begin
            // drop the taken result unless a new one replaces it this cycle
            if (out_valid_reg && !out_stall && !fin_go)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        state_reg <= (op_t'(op) == OP_START) ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN:
                begin
                    // issue read of entry cnt, evaluate entry cnt-1
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(CHANNEL_COUNT))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (fin_go)
                    begin
                        out_valid_reg <= 1'b1;
                        if ((op_reg == OP_START) && pick.hit)
                        begin
                            found_reg  <= 1'b1;
                            picked_reg <= 5'(pick.idx);
                        end
                        else
                        begin
                            found_reg  <= 1'b0;
                            picked_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign picked_index = picked_reg;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(CHANNEL_COUNT)))
        else $error("scan counter ran past the table");

    a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_SCAN && state_reg == ST_FINISH)
        |-> ($past(cnt_reg) == CNT_W'(CHANNEL_COUNT)))
        else $error("scan left before every entry was evaluated");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside the finish step");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tcmd.wr_en |-> (32'(tcmd.wr_idx) < 32'(CHANNEL_COUNT)))
        else $error("table write beyond the channel count");
`endif

endmodule
`default_nettype wire
